@@ sv/cpct_pkg.sv @@
// Shared constants and types of the collision pair contact tracker.
`default_nettype none

package cpct_pkg;

    localparam int MAX_COLLIDERS = 64;
    localparam int ID_W          = 6;
    localparam int POS_W         = 24;
    localparam int SCALE_W       = 16;
    localparam int UNIT_W        = 10;
    localparam int SIZE_W        = SCALE_W + UNIT_W;      // scale * unit_size
    localparam int REACH_W       = SIZE_W + 1;            // sum of two sizes
    localparam int DIST_W        = SIZE_W + 2;            // doubled centre difference
    localparam int PAIR_DEPTH    = MAX_COLLIDERS * MAX_COLLIDERS;
    localparam int PAIR_AW       = $clog2(PAIR_DEPTH);

    localparam logic [UNIT_W-1:0] UNIT_RESET = UNIT_W'(100);

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_ENTER = 2'd1,
        EV_STAY  = 2'd2,
        EV_EXIT  = 2'd3
    } t_event;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SIZE,
        S_DIST,
        S_SQR,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

@@ sv/collision_pair_contact_tracker_core.sv @@
// Top level of the collision pair contact tracker.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one pair check per item: ids,
//   shapes, positions and scales of a left and a right collider. Output
//   channel (o_valid / i_ready) returns one item per input: contact_event
//   (none, enter, stay, exit) and touching.
//   i_cfg_we / i_cfg_data write unit_size; write it only while idle.
//   The accepted item walks a chain of stages (size multiply, centre
//   difference, squaring, compare and contact-table write-back) that share
//   one set of registers, so only one item is inside; a new item is taken
//   only after the last result is loaded into the output register.
//   The contact flags live in a 4096 x 1 RAM, read at accept and written
//   back in the last step; one item at a time means no read can see a stale
//   flag.
//   Reset: unit_size returns to 100, and a clearing pass zeroes the contact
//   RAM one entry per cycle, with o_ready low throughout.
//   Stall: a result waits in the output register; if it is still not taken
//   when the next result is ready, the block holds in its last step.
`default_nettype none

module collision_pair_contact_tracker_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration
    input  wire logic                            i_cfg_we,
    input  wire logic [cpct_pkg::UNIT_W-1:0]     i_cfg_data,
    // input channel
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [cpct_pkg::ID_W-1:0]       i_left_id,
    input  wire logic [cpct_pkg::ID_W-1:0]       i_right_id,
    input  wire logic                            i_left_is_circle,
    input  wire logic                            i_right_is_circle,
    input  wire logic signed [cpct_pkg::POS_W-1:0] i_left_x,
    input  wire logic signed [cpct_pkg::POS_W-1:0] i_left_y,
    input  wire logic [cpct_pkg::SCALE_W-1:0]    i_left_scale_x,
    input  wire logic [cpct_pkg::SCALE_W-1:0]    i_left_scale_y,
    input  wire logic signed [cpct_pkg::POS_W-1:0] i_right_x,
    input  wire logic signed [cpct_pkg::POS_W-1:0] i_right_y,
    input  wire logic [cpct_pkg::SCALE_W-1:0]    i_right_scale_x,
    input  wire logic [cpct_pkg::SCALE_W-1:0]    i_right_scale_y,
    // output channel
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [1:0]                           o_contact_event,
    output logic                                 o_touching
);

    localparam int PAW  = cpct_pkg::PAIR_AW;
    localparam int SW   = cpct_pkg::SIZE_W;
    localparam int RW   = cpct_pkg::REACH_W;
    localparam int DW   = cpct_pkg::DIST_W;
    localparam int PW   = cpct_pkg::POS_W;
    localparam int SCW  = cpct_pkg::SCALE_W;

    // control
    cpct_pkg::t_state r_state, n_state;
    logic [PAW-1:0]   r_clr_cnt;
    logic [cpct_pkg::UNIT_W-1:0] r_unit;

    // captured item
    logic           r_pair_ok;
    logic [PAW-1:0] r_pair_idx;
    logic           r_lc, r_rc;
    logic signed [PW-1:0] r_lx, r_ly, r_rx, r_ry;
    logic [SCW-1:0] r_lsx, r_lsy, r_rsx, r_rsy;

    // stage registers
    logic           r_prev;
    logic [SW-1:0]  r_lw, r_lh, r_rw, r_rh;
    logic signed [PW:0] r_dx, r_dy;
    logic [DW-1:0]  r_adx, r_ady;
    logic [RW-1:0]  r_reach;
    logic           r_rect_touch;
    logic [2*DW-1:0] r_sqx, r_sqy;
    logic [2*RW-1:0] r_sqr;

    // output register
    logic              r_out_valid;
    cpct_pkg::t_event  r_event;
    logic              r_touch;

    // handshake and RAM control
    logic           w_accept;
    logic           w_load_out;
    logic           w_ram_we;
    logic [PAW-1:0] w_ram_waddr;
    logic           w_ram_wdata;
    logic           w_ram_rdata;
    logic           w_in_pair_ok;
    logic [PAW-1:0] w_in_pair_idx;

    // combinational datapath
    logic signed [DW-1:0] w_dsx, w_dsy;
    logic [PW:0]    w_rdx, w_rdy;
    logic [RW-1:0]  w_reach, w_reach_y;
    logic [2*DW:0]  w_sum;
    logic           w_circ_touch;
    logic           w_touch;
    cpct_pkg::t_event w_event;

    assign w_in_pair_ok = (i_left_id != i_right_id)
                       && (int'(i_left_id) < cpct_pkg::MAX_COLLIDERS)
                       && (int'(i_right_id) < cpct_pkg::MAX_COLLIDERS);
    assign w_in_pair_idx = PAW'(int'(i_left_id) * cpct_pkg::MAX_COLLIDERS
                              + int'(i_right_id));

    // ---------------------------------------------------------------
    // Sequencer: clear the table, take an item, walk it through the stages
    // ---------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        o_ready     = 1'b0;
        w_load_out  = 1'b0;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_pair_idx;
        w_ram_wdata = w_touch;
        unique case (r_state)
            cpct_pkg::S_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr_cnt;
                w_ram_wdata = 1'b0;
                if (r_clr_cnt == PAW'(cpct_pkg::PAIR_DEPTH - 1)) begin
                    n_state = cpct_pkg::S_IDLE;
                end
            end
            cpct_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = cpct_pkg::S_SIZE;
                end
            end
            cpct_pkg::S_SIZE: n_state = cpct_pkg::S_DIST;
            cpct_pkg::S_DIST: n_state = cpct_pkg::S_SQR;
            cpct_pkg::S_SQR:  n_state = cpct_pkg::S_DONE;
            cpct_pkg::S_DONE: begin
                // hold here while the previous result is still not taken
                if (!r_out_valid || i_ready) begin
                    w_load_out = 1'b1;
                    w_ram_we   = r_pair_ok;
                    n_state    = cpct_pkg::S_IDLE;
                end
            end
            default: n_state = cpct_pkg::S_CLEAR;
        endcase
    end

    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cpct_pkg::S_CLEAR;
            r_clr_cnt <= '0;
            r_unit    <= cpct_pkg::UNIT_RESET;
        end else begin
            r_state <= n_state;
            if (r_state == cpct_pkg::S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cfg_we) begin
                r_unit <= i_cfg_data;
            end
        end
    end

    // Contact flag table: read at accept, data lands in S_SIZE
    cpct_ram #(
        .WIDTH (1),
        .DEPTH (cpct_pkg::PAIR_DEPTH)
    ) u_contact_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_accept),
        .i_raddr (w_in_pair_idx),
        .o_rdata (w_ram_rdata)
    );

    // Capture the item
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pair_ok  <= w_in_pair_ok;
            r_pair_idx <= w_in_pair_idx;
            r_lc       <= i_left_is_circle;
            r_rc       <= i_right_is_circle;
            r_lx       <= i_left_x;
            r_ly       <= i_left_y;
            r_rx       <= i_right_x;
            r_ry       <= i_right_y;
            r_lsx      <= i_left_scale_x;
            r_lsy      <= i_left_scale_y;
            r_rsx      <= i_right_scale_x;
            r_rsy      <= i_right_scale_y;
        end
    end

    // S_SIZE: sizes from scale times unit, position differences, stored flag
    always_ff @(posedge i_clk) begin
        if (r_state == cpct_pkg::S_SIZE) begin
            r_prev <= w_ram_rdata;
            r_lw   <= SW'(r_lsx) * SW'(r_unit);
            r_lh   <= SW'(r_lsy) * SW'(r_unit);
            r_rw   <= SW'(r_rsx) * SW'(r_unit);
            r_rh   <= SW'(r_rsy) * SW'(r_unit);
            r_dx   <= (PW+1)'(r_lx) - (PW+1)'(r_rx);
            r_dy   <= (PW+1)'(r_ly) - (PW+1)'(r_ry);
        end
    end

    // S_DIST: doubled centre differences and the rectangle test
    always_comb begin
        w_dsx = $signed({{2{r_dx[PW]}}, r_dx, 1'b0})
              + ($signed({2'b00, r_lw}) - $signed({2'b00, r_rw}));
        w_dsy = $signed({{2{r_dy[PW]}}, r_dy, 1'b0})
              + ($signed({2'b00, r_lh}) - $signed({2'b00, r_rh}));
        w_rdx     = r_dx[PW] ? (PW+1)'(-r_dx) : (PW+1)'(r_dx);
        w_rdy     = r_dy[PW] ? (PW+1)'(-r_dy) : (PW+1)'(r_dy);
        w_reach   = {1'b0, r_lw} + {1'b0, r_rw};
        w_reach_y = {1'b0, r_lh} + {1'b0, r_rh};
    end

    always_ff @(posedge i_clk) begin
        if (r_state == cpct_pkg::S_DIST) begin
            r_adx        <= w_dsx[DW-1] ? DW'(-w_dsx) : DW'(w_dsx);
            r_ady        <= w_dsy[DW-1] ? DW'(-w_dsy) : DW'(w_dsy);
            r_reach      <= w_reach;
            r_rect_touch <= ({1'b0, w_rdx, 1'b0} < w_reach)
                         && ({1'b0, w_rdy, 1'b0} < w_reach_y);
        end
    end

    // S_SQR: squares for the circle test
    always_ff @(posedge i_clk) begin
        if (r_state == cpct_pkg::S_SQR) begin
            r_sqx <= (2*DW)'(r_adx) * (2*DW)'(r_adx);
            r_sqy <= (2*DW)'(r_ady) * (2*DW)'(r_ady);
            r_sqr <= (2*RW)'(r_reach) * (2*RW)'(r_reach);
        end
    end

    // S_DONE: decide touching and the event
    always_comb begin
        w_sum        = {1'b0, r_sqx} + {1'b0, r_sqy};
        w_circ_touch = w_sum <= (2*DW+1)'(r_sqr);
        if (!r_pair_ok) begin
            w_touch = 1'b0;
        end else if (r_lc && r_rc) begin
            w_touch = w_circ_touch;
        end else if (!r_lc && !r_rc) begin
            w_touch = r_rect_touch;
        end else begin
            w_touch = 1'b0;     // mixed shapes never touch
        end
        if (w_touch) begin
            w_event = r_prev ? cpct_pkg::EV_STAY : cpct_pkg::EV_ENTER;
        end else if (r_pair_ok && r_prev) begin
            w_event = cpct_pkg::EV_EXIT;
        end else begin
            w_event = cpct_pkg::EV_NONE;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_event <= w_event;
            r_touch <= w_touch;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_contact_event = r_event;
    assign o_touching      = r_touch;

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cpct_pkg::S_CLEAR) |-> !o_ready)
        else $error("item accepted during table clear");

    a_accept_starts_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == cpct_pkg::S_SIZE))
        else $error("accepted item did not enter the size stage");

    a_ram_write_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ram_we |-> (r_state == cpct_pkg::S_CLEAR || r_state == cpct_pkg::S_DONE))
        else $error("contact table written outside clear or write-back");

    a_bad_pair_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cpct_pkg::S_DONE && !r_pair_ok) |-> !w_ram_we)
        else $error("contact table written for an invalid pair");

    a_touch_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_touching) |->
            (r_event == cpct_pkg::EV_ENTER || r_event == cpct_pkg::EV_STAY))
        else $error("touching result without enter or stay");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !w_load_out)
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

@@ sv/cpct_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none

module cpct_ram #(
    parameter int  WIDTH = 1,
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
